FILE: rtl/ip6p_pkg.sv
// Shared types, constants and the hex digit decoder of the IPv6 text address parser.
package ip6p_pkg;

    localparam int CHAR_W  = 8;
    localparam int NIB_W   = 4;
    localparam int GROUP_W = 16;
    localparam int GROUP_N = 8;
    localparam int GIDX_W  = 3;
    localparam int GCNT_W  = 4;
    localparam int HALF_W  = 64;
    localparam int ADDR_W  = 128;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_TEN    = 8'd10;

    // Command from the character stage to the group file.
    typedef struct packed {
        logic                write;
        logic                to_tail;
        logic [GIDX_W-1:0]   index;
        logic [GROUP_W-1:0]  data;
        logic                clear;
    } t_group_cmd;

    typedef struct packed {
        logic             is_hex;
        logic [NIB_W-1:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] c);
        t_hex              r;
        logic [CHAR_W-1:0] d;
        r.is_hex = 1'b1;
        d        = '0;
        case (c) inside
            [CHAR_0:CHAR_9]:   d = c - CHAR_0;
            [CHAR_LA:CHAR_LF]: d = c - CHAR_LA + HEX_TEN;
            [CHAR_UA:CHAR_UF]: d = c - CHAR_UA + HEX_TEN;
            default:           r.is_hex = 1'b0;
        endcase
        r.nib = d[NIB_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/ip6p_ifs.sv
// Stream interfaces of the parser: the character channel and the address channel.
interface ip6p_char_if;
    logic                          valid;
    logic                          ready;
    logic [ip6p_pkg::CHAR_W-1:0]   character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface ip6p_addr_if;
    logic                          valid;
    logic                          ready;
    logic [ip6p_pkg::HALF_W-1:0]   address_upper;
    logic [ip6p_pkg::HALF_W-1:0]   address_lower;
    logic                          ok;

    modport source (output valid, output address_upper, output address_lower, output ok,
                    input ready);
    modport sink   (input valid, input address_upper, input address_lower, input ok,
                    output ready);
endinterface

FILE: rtl/ip6p_group_file.sv
// Group file: head groups written in place, tail groups after the gap shifted in from the right.
module ip6p_group_file (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ip6p_pkg::t_group_cmd          i_cmd,
    output logic [ip6p_pkg::ADDR_W-1:0]   o_view
);

    logic [ip6p_pkg::GROUP_W-1:0] r_head [ip6p_pkg::GROUP_N];
    logic [ip6p_pkg::GROUP_W-1:0] r_tail [ip6p_pkg::GROUP_N];
    logic [ip6p_pkg::GROUP_W-1:0] n_head [ip6p_pkg::GROUP_N];
    logic [ip6p_pkg::GROUP_W-1:0] n_tail [ip6p_pkg::GROUP_N];

    always_comb begin
        for (int i = 0; i < ip6p_pkg::GROUP_N; i++) begin
            n_head[i] = r_head[i];
            n_tail[i] = r_tail[i];
        end
        if (i_cmd.write) begin
            if (i_cmd.to_tail) begin
                for (int i = 0; i < ip6p_pkg::GROUP_N - 1; i++) begin
                    n_tail[i] = r_tail[i+1];
                end
                n_tail[ip6p_pkg::GROUP_N-1] = i_cmd.data;
            end else begin
                n_head[i_cmd.index] = i_cmd.data;
            end
        end
    end

    // Unwritten slots hold zero, so the gap falls out of a plain OR.
    always_comb begin
        for (int i = 0; i < ip6p_pkg::GROUP_N; i++) begin
            o_view[ip6p_pkg::ADDR_W-1-i*ip6p_pkg::GROUP_W -: ip6p_pkg::GROUP_W] =
                n_head[i] | n_tail[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < ip6p_pkg::GROUP_N; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            for (int i = 0; i < ip6p_pkg::GROUP_N; i++) begin
                r_head[i] <= n_head[i];
                r_tail[i] <= n_tail[i];
            end
        end
    end

endmodule

FILE: rtl/ipv6_text_address_parser.sv
// Top level of the IPv6 text address parser: character stage, group file and result register.
//
//  channel   dir  modport  payload                                  transfers
//  i_char    in   sink     character[7:0]                           one per text character
//  o_addr    out  source   address_upper[63:0], address_lower[63:0], ok   one per terminator
//
//  Flow: a terminator passes through the input register and then the result register, whose
//  load raises o_addr.valid.
//  The character stage and the result register share one advance enable, so the rate is
//  one character per cycle whenever o_addr is not stalled.
//  Reset (i_rst_n low, synchronous) drops both stage valids and clears the parse state.
//  Stall: while a result waits untaken, the whole pipe holds and i_char.ready is low.
//  After each terminator the parse state returns to its reset value for the next string.
module ipv6_text_address_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ip6p_char_if.sink      i_char,
    ip6p_addr_if.source    o_addr
);

    // Pipe advance: the result register is free or being emptied this cycle.
    logic adv;

    // Input register.
    logic                          r_in_valid;
    logic [ip6p_pkg::CHAR_W-1:0]   r_char;

    // Parse state.
    logic [ip6p_pkg::GROUP_W-1:0]  r_acc, n_acc;
    logic                          r_has_digit, n_has_digit;
    logic                          r_gap, n_gap;
    logic [ip6p_pkg::GCNT_W-1:0]   r_groups, n_groups;
    logic                          r_failed, n_failed;
    logic                          r_first, n_first;

    // Result register.
    logic                          r_out_valid;
    logic [ip6p_pkg::HALF_W-1:0]   r_upper, n_upper;
    logic [ip6p_pkg::HALF_W-1:0]   r_lower, n_lower;
    logic                          r_ok, n_ok;

    ip6p_pkg::t_group_cmd          cmd;
    logic [ip6p_pkg::ADDR_W-1:0]   view;
    ip6p_pkg::t_hex                hex;
    logic                          room;
    logic                          term_fire;
    logic                          term_store;
    logic                          term_fail;
    logic [ip6p_pkg::GCNT_W-1:0]   term_groups;

    assign adv          = !r_out_valid || o_addr.ready;
    assign i_char.ready = adv;

    assign hex       = ip6p_pkg::hex_decode(r_char);
    assign room      = r_groups < ip6p_pkg::GCNT_W'(ip6p_pkg::GROUP_N);
    assign term_fire = r_in_valid && adv && (r_char == ip6p_pkg::CHAR_NUL);

    // The terminator stores a pending group if there is one and the string is still good.
    assign term_store  = !r_failed && r_has_digit && room;
    assign term_fail   = r_failed || (r_has_digit && !room);
    assign term_groups = r_groups + ip6p_pkg::GCNT_W'(term_store);

    always_comb begin
        n_acc       = r_acc;
        n_has_digit = r_has_digit;
        n_gap       = r_gap;
        n_groups    = r_groups;
        n_failed    = r_failed;
        n_first     = r_first;
        n_upper     = '0;
        n_lower     = '0;
        n_ok        = 1'b0;
        cmd         = '0;
        cmd.to_tail = r_gap;
        cmd.index   = r_groups[ip6p_pkg::GIDX_W-1:0];
        cmd.data    = r_acc;

        if (r_in_valid && adv) begin
            if (r_char != ip6p_pkg::CHAR_NUL) begin
                n_first = 1'b0;
                // After a failure, drop characters until the terminator.
                if (!r_failed) begin
                    if (hex.is_hex) begin
                        // A fifth significant digit would overflow the group.
                        if (r_acc[ip6p_pkg::GROUP_W-1 -: ip6p_pkg::NIB_W] != '0) begin
                            n_failed = 1'b1;
                        end else begin
                            n_acc = {r_acc[ip6p_pkg::GROUP_W-ip6p_pkg::NIB_W-1:0], hex.nib};
                            n_has_digit = 1'b1;
                        end
                    end else if (r_char == ip6p_pkg::CHAR_COLON) begin
                        // A leading colon is skipped.
                        if (!r_first) begin
                            if (!r_has_digit) begin
                                // Colon with no digits marks the gap; only one is allowed.
                                if (r_gap) begin
                                    n_failed = 1'b1;
                                end else begin
                                    n_gap = 1'b1;
                                end
                            end else if (room) begin
                                cmd.write   = 1'b1;
                                n_groups    = r_groups + ip6p_pkg::GCNT_W'(1);
                                n_acc       = '0;
                                n_has_digit = 1'b0;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                    end else begin
                        n_failed = 1'b1;
                    end
                end
            end else begin
                // Terminator: fold in the pending group, emit, and restart.
                cmd.write = term_store;
                cmd.clear = 1'b1;
                n_ok      = !term_fail && (r_gap ||
                            term_groups == ip6p_pkg::GCNT_W'(ip6p_pkg::GROUP_N));
                if (n_ok) begin
                    n_upper = view[ip6p_pkg::ADDR_W-1 -: ip6p_pkg::HALF_W];
                    n_lower = view[ip6p_pkg::HALF_W-1:0];
                end
                n_acc       = '0;
                n_has_digit = 1'b0;
                n_gap       = 1'b0;
                n_groups    = '0;
                n_failed    = 1'b0;
                n_first     = 1'b1;
            end
        end
    end

    ip6p_group_file u_group_file (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_view  (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_has_digit <= 1'b0;
            r_gap       <= 1'b0;
            r_groups    <= '0;
            r_failed    <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_has_digit <= n_has_digit;
            r_gap       <= n_gap;
            r_groups    <= n_groups;
            r_failed    <= n_failed;
            r_first     <= n_first;
            if (adv) begin
                r_in_valid  <= i_char.valid;
                r_out_valid <= term_fire;
            end
        end
    end

    // Payload registers: load on advance, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_char  <= i_char.character;
            r_upper <= n_upper;
            r_lower <= n_lower;
            r_ok    <= n_ok;
        end
    end

    assign o_addr.valid         = r_out_valid;
    assign o_addr.address_upper = r_upper;
    assign o_addr.address_lower = r_lower;
    assign o_addr.ok            = r_ok;

    a_groups_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_groups <= ip6p_pkg::GCNT_W'(ip6p_pkg::GROUP_N))
        else $error("group count beyond eight");

    a_acc_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc != '0) |-> r_has_digit)
        else $error("nonzero group without a digit");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ok) |-> (r_upper == '0 && r_lower == '0))
        else $error("failed result carries a nonzero address");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        term_fire |=> (r_first && !r_gap && !r_failed && r_groups == '0 && r_out_valid))
        else $error("terminator did not restart the parse and post a result");

endmodule

FILE: dv/ipv6_text_address_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the IPv6 text address parser: directed and random address text.
module ipv6_text_address_parser_tb;

    // Result of one terminated string, as the parser should report it.
    typedef struct {
        logic [ip6p_pkg::HALF_W-1:0] upper;
        logic [ip6p_pkg::HALF_W-1:0] lower;
        logic                        ok;
    } t_addr_result;

    // Characters sent over the whole run, directed tests included.
    localparam int TOTAL_CHARS = 1500;

    logic i_clk;
    logic i_rst_n;

    ip6p_char_if char_bus ();
    ip6p_addr_if addr_bus ();

    ipv6_text_address_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_addr  (addr_bus)
    );

    // Parse state of the predictor; mirrors what the block holds between characters.
    logic [ip6p_pkg::GROUP_W-1:0] grp_acc;
    logic                         grp_has_digit;
    logic                         gap_marked;
    logic [ip6p_pkg::GCNT_W-1:0]  gap_at;
    logic [ip6p_pkg::GCNT_W-1:0]  grp_count;
    logic [ip6p_pkg::GROUP_W-1:0] grp_store [ip6p_pkg::GROUP_N];
    logic                         text_failed;
    logic                         at_start;

    t_addr_result expected_addrs[$];            // one entry per terminator transfer
    logic [ip6p_pkg::CHAR_W-1:0] text_buf[$];   // characters of the string being built
    int    error_count = 0;
    int    chars_sent  = 0;
    bit    idle_on     = 1'b1;                  // random gaps on both channels
    int    stall_left  = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return 0..15 for a hex digit of either case, 16 for anything else.
    function automatic int nibble_of(logic [ip6p_pkg::CHAR_W-1:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return 16;
    endfunction

    function automatic void clear_parse();
        grp_acc       = '0;
        grp_has_digit = 1'b0;
        gap_marked    = 1'b0;
        gap_at        = '0;
        grp_count     = '0;
        text_failed   = 1'b0;
        at_start      = 1'b1;
        for (int i = 0; i < ip6p_pkg::GROUP_N; i++) grp_store[i] = '0;
    endfunction

    // Commit the pending group; a ninth group rejects the string.
    function automatic void store_group();
        if (grp_count < ip6p_pkg::GROUP_N) begin
            grp_store[grp_count[ip6p_pkg::GIDX_W-1:0]] = grp_acc;
            grp_count     = grp_count + ip6p_pkg::GCNT_W'(1);
            grp_acc       = '0;
            grp_has_digit = 1'b0;
        end else begin
            text_failed = 1'b1;
        end
    endfunction

    // Advance the parse by one accepted character; a terminator queues the address.
    function automatic void parse_char(logic [ip6p_pkg::CHAR_W-1:0] c);
        int                           nib;
        logic                         was_start;
        int                           gp;
        int                           cnt;
        logic [ip6p_pkg::GROUP_W-1:0] fin [ip6p_pkg::GROUP_N];
        t_addr_result                 res;
        if (c != ip6p_pkg::CHAR_NUL) begin
            was_start = at_start;
            at_start  = 1'b0;
            if (text_failed) return;
            nib = nibble_of(c);
            if (nib < 16) begin
                // a fifth significant digit would overflow the group
                if (grp_acc[ip6p_pkg::GROUP_W-1 -: ip6p_pkg::NIB_W] != '0) begin
                    text_failed = 1'b1;
                end else begin
                    grp_acc = {grp_acc[ip6p_pkg::GROUP_W-ip6p_pkg::NIB_W-1:0],
                               nib[ip6p_pkg::NIB_W-1:0]};
                    grp_has_digit = 1'b1;
                end
            end else if (c == ip6p_pkg::CHAR_COLON) begin
                if (was_start) begin
                    // leading colon: skip it
                end else if (!grp_has_digit) begin
                    if (gap_marked) begin
                        text_failed = 1'b1;
                    end else begin
                        gap_marked = 1'b1;
                        gap_at     = grp_count;
                    end
                end else begin
                    store_group();
                end
            end else begin
                text_failed = 1'b1;
            end
            return;
        end

        if (!text_failed && grp_has_digit) store_group();
        for (int i = 0; i < ip6p_pkg::GROUP_N; i++) fin[i] = '0;
        res.ok = 1'b0;
        if (!text_failed) begin
            if (gap_marked) begin
                // groups before the gap stay in front, the rest move to the tail
                gp  = (gap_at <= grp_count) ? int'(gap_at) : int'(grp_count);
                cnt = int'(grp_count) - gp;
                for (int i = 0; i < gp; i++) fin[i] = grp_store[i];
                for (int i = 0; i < cnt; i++)
                    fin[ip6p_pkg::GROUP_N - cnt + i] = grp_store[gp + i];
                res.ok = 1'b1;
            end else if (grp_count == ip6p_pkg::GROUP_N) begin
                for (int i = 0; i < ip6p_pkg::GROUP_N; i++) fin[i] = grp_store[i];
                res.ok = 1'b1;
            end
        end
        res.upper = {fin[0], fin[1], fin[2], fin[3]};
        res.lower = {fin[4], fin[5], fin[6], fin[7]};
        expected_addrs.push_back(res);
        clear_parse();
    endfunction

    // ------------------------------------------------------------------
    // Character channel
    // ------------------------------------------------------------------

    // Drive one character and hold it until the transfer; predict on the transfer.
    task automatic send_char(logic [ip6p_pkg::CHAR_W-1:0] c);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.character <= c;
        do @(posedge i_clk); while (!char_bus.ready);
        parse_char(c);
        chars_sent++;
    endtask

    // Send the built string followed by its terminator, then empty the buffer.
    task automatic send_text_buf();
        foreach (text_buf[i]) send_char(text_buf[i]);
        send_char(ip6p_pkg::CHAR_NUL);
        text_buf.delete();
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text_buf();
    endtask

    // ------------------------------------------------------------------
    // Address channel: random stall bursts and the result check
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            addr_bus.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            addr_bus.ready <= 1'b0;
        end else begin
            addr_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_addr_result want;
        if (i_rst_n && addr_bus.valid && addr_bus.ready) begin
            if (expected_addrs.size() == 0) begin
                $display("%0t: address result with none pending: upper %h lower %h ok %b",
                         $time, addr_bus.address_upper, addr_bus.address_lower, addr_bus.ok);
                error_count++;
            end else begin
                want = expected_addrs.pop_front();
                if (addr_bus.address_upper !== want.upper) begin
                    $display("%0t: address_upper expected %h actual %h",
                             $time, want.upper, addr_bus.address_upper);
                    error_count++;
                end
                if (addr_bus.address_lower !== want.lower) begin
                    $display("%0t: address_lower expected %h actual %h",
                             $time, want.lower, addr_bus.address_lower);
                    error_count++;
                end
                if (addr_bus.ok !== want.ok) begin
                    $display("%0t: ok expected %b actual %b", $time, want.ok, addr_bus.ok);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random text generation
    // ------------------------------------------------------------------

    function automatic logic [ip6p_pkg::CHAR_W-1:0] hex_char(logic [ip6p_pkg::NIB_W-1:0] nib);
        if (nib < 10) return ip6p_pkg::CHAR_0 + nib;
        return ($urandom_range(0, 1) ? ip6p_pkg::CHAR_UA : ip6p_pkg::CHAR_LA) + nib - 4'd10;
    endfunction

    function automatic logic [ip6p_pkg::GROUP_W-1:0] pick_group();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return ip6p_pkg::GROUP_W'($urandom_range(0, 255));
            default: return ip6p_pkg::GROUP_W'($urandom);
        endcase
    endfunction

    // Append a group with a random digit count, now and then with extra leading zeros.
    function automatic void append_group(logic [ip6p_pkg::GROUP_W-1:0] v);
        int need;
        int digits;
        need = (v[15:12] != 0) ? 4 : (v[11:8] != 0) ? 3 : (v[7:4] != 0) ? 2 : 1;
        if ($urandom_range(0, 7) == 0) digits = need + $urandom_range(0, 3);
        else                           digits = need + $urandom_range(0, 4 - need);
        for (int i = digits - 1; i >= 0; i--)
            text_buf.push_back(hex_char(i < 4 ? v[i*4 +: 4] : 4'h0));
    endfunction

    function automatic void append_groups(int n);
        for (int i = 0; i < n; i++) begin
            if (i > 0) text_buf.push_back(ip6p_pkg::CHAR_COLON);
            append_group(pick_group());
        end
    endfunction

    // Build a well-formed address: eight groups, or a zero gap with 0..8 groups around it.
    function automatic void build_address();
        int head;
        int tail;
        if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 5) == 0) text_buf.push_back(ip6p_pkg::CHAR_COLON);
            append_groups(ip6p_pkg::GROUP_N);
        end else begin
            head = $urandom_range(0, ip6p_pkg::GROUP_N - 1);
            tail = $urandom_range(0, ip6p_pkg::GROUP_N - 1 - head);
            // rarely let the gap stand for no group at all
            if ($urandom_range(0, 9) == 0) tail = ip6p_pkg::GROUP_N - head;
            append_groups(head);
            text_buf.push_back(ip6p_pkg::CHAR_COLON);
            text_buf.push_back(ip6p_pkg::CHAR_COLON);
            append_groups(tail);
        end
    endfunction

    // Change a well-formed address in one random way; the result may still be well-formed.
    function automatic void break_address();
        int pos;
        build_address();
        pos = $urandom_range(0, text_buf.size());
        case ($urandom_range(0, 5))
            0: text_buf.insert(pos, ip6p_pkg::CHAR_W'($urandom_range(1, 255)));
            1: if (pos < text_buf.size()) text_buf.delete(pos);
            2: text_buf.insert(pos, ip6p_pkg::CHAR_COLON);
            3: begin
                text_buf.push_back(ip6p_pkg::CHAR_COLON);
                append_group(pick_group());
            end
            4: text_buf.insert(pos, hex_char(ip6p_pkg::NIB_W'($urandom_range(1, 15))));
            default: while (text_buf.size() > pos) void'(text_buf.pop_back());
        endcase
    endfunction

    // Short run of arbitrary nonzero bytes, biased toward digits and colons.
    function automatic void build_noise();
        int len;
        len = $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 2))
                0:       text_buf.push_back(ip6p_pkg::CHAR_COLON);
                1:       text_buf.push_back(hex_char(ip6p_pkg::NIB_W'($urandom)));
                default: text_buf.push_back(ip6p_pkg::CHAR_W'($urandom_range(1, 255)));
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_full_addresses();
        send_text("0:0:0:0:0:0:0:0");
        send_text("ffff:FFFF:fFfF:FfFf:ffff:ffff:ffff:ffff");
        send_text("1:2:3:4:5:6:7:8");
        // leading colon is skipped before a plain group
        send_text(":1:23:456:789a:bcDE:f:0:1");
    endtask

    task automatic test_zero_gaps();
        send_text("::");
        send_text("::1");
        send_text("1::");
        send_text("ab:CD::9");
        send_text("1:2:3:4::5:6:7:8");   // gap standing for nothing
        send_text("1:2:3:4:5:6:7:8:");   // trailing colon stores the last group
    endtask

    task automatic test_group_limits();
        send_text("00000001::");         // leading zeros past four digits
        send_text("12345::");            // long group
        send_text("ffff0::");
    endtask

    task automatic test_rejected_text();
        send_text("");                   // empty string
        send_text(":");
        send_text(":::");                // second gap right after the first
        send_text("1::2::3");
        send_text("1:2:3");              // too few groups
        send_text("1:2:3:4:5:6:7:8:9");  // ninth group at the terminator
        send_text("1:2:3:4:5:6:7:8:9:"); // ninth group at a colon
        send_text("1::g");
        send_text("x1:2:3:4:5:6:7:8");   // rest ignored after failure
        send_text("/@G`g:");
        // bytes at the ends of the character range
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h80);
        text_buf.push_back(8'h7F);
        text_buf.push_back(8'h01);
        send_text_buf();
    endtask

    task automatic test_random_text();
        int kind;
        while (chars_sent < TOTAL_CHARS) begin
            // the last part of the run streams without gaps on either side
            idle_on = (chars_sent < TOTAL_CHARS * 4 / 5);
            kind = $urandom_range(0, 9);
            if (kind < 7)      build_address();
            else if (kind < 9) break_address();
            else               build_noise();
            send_text_buf();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n            = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.character = ip6p_pkg::CHAR_NUL;
        addr_bus.ready     = 1'b0;
        clear_parse();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_addresses();
        test_zero_gaps();
        test_group_limits();
        test_rejected_text();
        test_random_text();

        char_bus.valid <= 1'b0;
        while (expected_addrs.size() != 0) @(posedge i_clk);
        // results trail their terminator through the input and result registers
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_addrs.size() == 0) begin
            $display("ipv6_text_address_parser verification clean");
        end else begin
            $display("ipv6_text_address_parser verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("ipv6_text_address_parser verification failed");
        $finish;
    end

endmodule
